// File: sv/adts_pkg.sv
package adts_pkg;

   localparam int unsigned LEN_W       = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RSP_DATA_W  = 40;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd8191;
   localparam logic [LEN_W-1:0] HEADER_LEN    = 13'd7;

   // Positions of header bytes within a frame.
   localparam logic [LEN_W-1:0] POS_PROFILE  = 13'd2;
   localparam logic [LEN_W-1:0] POS_LEN_HIGH = 13'd3;
   localparam logic [LEN_W-1:0] POS_LEN_MID  = 13'd4;
   localparam logic [LEN_W-1:0] POS_LEN_LOW  = 13'd5;
   localparam logic [LEN_W-1:0] POS_HDR_END  = 13'd6;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_LONG  = 2'd1,
      ERR_SHORT = 2'd2
   } frame_err_type;

   // Listed from the highest bit down, so pad sits on top and out_byte at bit 0.
   typedef struct packed {
      logic [2:0]        pad;
      logic              info_valid;
      logic [7:0]        asc_byte1;
      logic [7:0]        asc_byte0;
      logic [2:0]        channel_config;
      logic [3:0]        rate_index;
      logic [2:0]        object_type;
      frame_err_type     frame_error;
      logic [BYTE_W-1:0] out_byte;
   } rsp_data_type;

   typedef struct packed {
      rsp_data_type data;
      logic         first;
      logic         last;
   } rsp_item_type;

endpackage

// File: sv/adts_frame_splitter_top.sv
// Channel  | Direction | Ports                      | Content
// req      | in        | req_tvalid/tready/tdata    | tdata[7:0] data_byte
// rsp      | out       | rsp_tvalid/tready/tdata/   | tdata: see port comment,
//          |           | tuser/tlast                | tuser frame_first, tlast frame_last
// csr      | in        | csr_we/csr_wdata           | max_frame_len
//
// One item per clock while rsp is not stalled: every byte is parsed in the cycle it is accepted,
// and its result reaches rsp through the output register.
// A skid register behind the output register keeps req ready for one more item while
// rsp is stalled; req_tready drops only once the skid register holds an item.
// Reset is synchronous and clears the frame position, length, header info and sets
// max_frame_len to 8191.
module adts_frame_splitter_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [adts_pkg::BYTE_W-1:0]            req_tdata,   // [7:0] data_byte
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] out_byte, [9:8] frame_error, [12:10] object_type, [16:13] rate_index,
   // [19:17] channel_config, [27:20] asc_byte0, [35:28] asc_byte1, [36] info_valid,
   // [39:37] zero
   output logic [adts_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tuser,   // [0] frame_first
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [adts_pkg::LEN_W-1:0]             csr_wdata
);
   import adts_pkg::*;

   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] byte_index_ff, byte_index_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [7:0]       hdr_two_ff, hdr_two_in;
   logic [2:0]       obj_type_ff, obj_type_in;
   logic [3:0]       rate_idx_ff, rate_idx_in;
   logic [2:0]       channels_ff, channels_in;
   logic             seen_ff, seen_in;

   rsp_item_type     out_ff, skid_ff, item_in;
   logic             out_valid_ff, skid_valid_ff;

   logic             accept;
   logic             take;
   logic             last_c;
   frame_err_type    err_c;
   logic [LEN_W:0]   pos_next;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;
   assign pos_next   = {1'b0, byte_index_ff} + {{LEN_W{1'b0}}, 1'b1};

   always_comb begin
      hdr_two_in  = hdr_two_ff;
      obj_type_in = obj_type_ff;
      rate_idx_in = rate_idx_ff;
      channels_in = channels_ff;
      seen_in     = seen_ff;
      frame_len_in = frame_len_ff;
      case (byte_index_ff)
         POS_PROFILE: begin
            hdr_two_in = req_tdata;
         end
         POS_LEN_HIGH: begin
            obj_type_in  = {1'b0, hdr_two_ff[7:6]} + 3'd1;
            rate_idx_in  = hdr_two_ff[5:2];
            channels_in  = {hdr_two_ff[0], req_tdata[7:6]};
            seen_in      = 1'b1;
            frame_len_in = {req_tdata[1:0], 11'd0};
         end
         POS_LEN_MID: begin
            frame_len_in = frame_len_ff | {2'd0, req_tdata, 3'd0};
         end
         POS_LEN_LOW: begin
            frame_len_in = frame_len_ff | {10'd0, req_tdata[7:5]};
         end
         default: begin
         end
      endcase

      last_c = 1'b0;
      err_c  = ERR_NONE;
      if (byte_index_ff >= POS_HDR_END) begin
         if (frame_len_ff < HEADER_LEN) begin
            last_c = 1'b1;
            err_c  = ERR_SHORT;
         end else if (pos_next >= {1'b0, frame_len_ff}) begin
            last_c = 1'b1;
            err_c  = (frame_len_ff > max_len_ff) ? ERR_LONG : ERR_NONE;
         end
      end
      byte_index_in = last_c ? '0 : pos_next[LEN_W-1:0];

      item_in.first                = (byte_index_ff == '0);
      item_in.last                 = last_c;
      item_in.data.pad             = '0;
      item_in.data.info_valid      = seen_in;
      item_in.data.asc_byte1       = {rate_idx_in[0], 1'b0, channels_in, 3'd0};
      item_in.data.asc_byte0       = {2'd0, obj_type_in, rate_idx_in[3:1]};
      item_in.data.channel_config  = channels_in;
      item_in.data.rate_index      = rate_idx_in;
      item_in.data.object_type     = obj_type_in;
      item_in.data.frame_error     = err_c;
      item_in.data.out_byte        = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LEN_RESET;
         byte_index_ff <= '0;
         frame_len_ff  <= '0;
         hdr_two_ff    <= '0;
         obj_type_ff   <= '0;
         rate_idx_ff   <= '0;
         channels_ff   <= '0;
         seen_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         if (accept) begin
            byte_index_ff <= byte_index_in;
            frame_len_ff  <= frame_len_in;
            hdr_two_ff    <= hdr_two_in;
            obj_type_ff   <= obj_type_in;
            rate_idx_ff   <= rate_idx_in;
            channels_ff   <= channels_in;
            seen_ff       <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= item_in;
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_ff       <= item_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= item_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.first;
   assign rsp_tlast  = out_ff.last;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds an item while the output register is empty.");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last_c |=> byte_index_ff == '0)
      else $error("Frame position did not restart after a last byte.");

   a_error_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.data.frame_error != ERR_NONE |-> rsp_tlast)
      else $error("Frame error shown on a byte that does not end a frame.");

   a_header_seen: assert property (@(posedge clock) disable iff (reset)
      accept && byte_index_ff == POS_LEN_HIGH |=> seen_ff)
      else $error("Header info not marked valid after header byte three.");

endmodule
